// ===== hdl/eois_pkg.sv =====
package eois_pkg;

   // fixed field and datapath widths
   localparam int FIELD_BITS     = 16;
   localparam int INDEX_BITS     = 10;
   localparam int DIGIT_BITS     = 16;
   localparam int DIGIT_CNT_BITS = 3;
   localparam int SLOT_BITS      = 5;
   localparam int PC_BITS        = 7;

   // item kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_PLANE  = 2'd1;
   localparam logic [1:0] KIND_SPHERE = 2'd2;

   // micro-op codes
   localparam logic [3:0] OP_FETCH = 4'd0;   // read vertex sel into the vertex register
   localparam logic [3:0] OP_WRV   = 4'd1;   // write the latched point into vertex slot
   localparam logic [3:0] OP_DIFF  = 4'd2;   // dst = vertex[sel] - point[sel]
   localparam logic [3:0] OP_SUM   = 4'd3;   // dst = vertex[sel] + point[sel]
   localparam logic [3:0] OP_SUB   = 4'd4;   // dst = a - b
   localparam logic [3:0] OP_MSET  = 4'd5;   // acc = a * b
   localparam logic [3:0] OP_MADD  = 4'd6;   // acc += a * b
   localparam logic [3:0] OP_MSUB  = 4'd7;   // acc -= a * b
   localparam logic [3:0] OP_STORE = 4'd8;   // dst = acc
   localparam logic [3:0] OP_DONE  = 4'd9;   // report sign of acc, sel[0] flips it
   localparam logic [3:0] OP_END   = 4'd10;  // finish without a result

   // program entry points
   localparam logic [PC_BITS-1:0] PC_SPHERE = 7'd0;
   localparam logic [PC_BITS-1:0] PC_PLANE  = 7'd87;
   localparam logic [PC_BITS-1:0] PC_LOAD   = 7'd118;

   // scratch slot map
   localparam int SL_X  = 0;
   localparam int SL_Y  = 4;
   localparam int SL_Z  = 8;
   localparam int SL_W  = 12;
   localparam int SL_A  = 16;
   localparam int SL_B  = 22;
   localparam int SL_S  = 28;
   localparam int SL_R1 = 16;
   localparam int SL_R2 = 19;
   localparam int SL_C  = 22;

   typedef logic [SLOT_BITS-1:0] slot_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] sel;
      slot_type   dst;
      slot_type   src_a;
      slot_type   src_b;
   } uop_type;

   typedef struct packed {
      logic                      latch;
      logic                      issue;
      logic                      exec;
      uop_type                   uop;
      logic [DIGIT_CNT_BITS-1:0] digit;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } stat_type;

   function automatic uop_type mk(input logic [3:0] op, input int sel, input int dst,
                                  input int a, input int b);
      uop_type u;
      u.op    = op;
      u.sel   = 2'(sel);
      u.dst   = slot_type'(dst);
      u.src_a = slot_type'(a);
      u.src_b = slot_type'(b);
      return u;
   endfunction

   // micro-program: sphere query, plane query, vertex load
   function automatic uop_type ucode(input logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         // sphere: per vertex i, x/y/z differences and w = sum (v+p)(v-p)
         7'd0:   u = mk(OP_FETCH, 0, 0, 0, 0);
         7'd1:   u = mk(OP_DIFF, 0, SL_X+0, 0, 0);
         7'd2:   u = mk(OP_DIFF, 1, SL_Y+0, 0, 0);
         7'd3:   u = mk(OP_DIFF, 2, SL_Z+0, 0, 0);
         7'd4:   u = mk(OP_SUM, 0, SL_S+0, 0, 0);
         7'd5:   u = mk(OP_SUM, 1, SL_S+1, 0, 0);
         7'd6:   u = mk(OP_SUM, 2, SL_S+2, 0, 0);
         7'd7:   u = mk(OP_MSET, 0, 0, SL_S+0, SL_X+0);
         7'd8:   u = mk(OP_MADD, 0, 0, SL_S+1, SL_Y+0);
         7'd9:   u = mk(OP_MADD, 0, 0, SL_S+2, SL_Z+0);
         7'd10:  u = mk(OP_STORE, 0, SL_W+0, 0, 0);
         7'd11:  u = mk(OP_FETCH, 1, 0, 0, 0);
         7'd12:  u = mk(OP_DIFF, 0, SL_X+1, 0, 0);
         7'd13:  u = mk(OP_DIFF, 1, SL_Y+1, 0, 0);
         7'd14:  u = mk(OP_DIFF, 2, SL_Z+1, 0, 0);
         7'd15:  u = mk(OP_SUM, 0, SL_S+0, 0, 0);
         7'd16:  u = mk(OP_SUM, 1, SL_S+1, 0, 0);
         7'd17:  u = mk(OP_SUM, 2, SL_S+2, 0, 0);
         7'd18:  u = mk(OP_MSET, 0, 0, SL_S+0, SL_X+1);
         7'd19:  u = mk(OP_MADD, 0, 0, SL_S+1, SL_Y+1);
         7'd20:  u = mk(OP_MADD, 0, 0, SL_S+2, SL_Z+1);
         7'd21:  u = mk(OP_STORE, 0, SL_W+1, 0, 0);
         7'd22:  u = mk(OP_FETCH, 2, 0, 0, 0);
         7'd23:  u = mk(OP_DIFF, 0, SL_X+2, 0, 0);
         7'd24:  u = mk(OP_DIFF, 1, SL_Y+2, 0, 0);
         7'd25:  u = mk(OP_DIFF, 2, SL_Z+2, 0, 0);
         7'd26:  u = mk(OP_SUM, 0, SL_S+0, 0, 0);
         7'd27:  u = mk(OP_SUM, 1, SL_S+1, 0, 0);
         7'd28:  u = mk(OP_SUM, 2, SL_S+2, 0, 0);
         7'd29:  u = mk(OP_MSET, 0, 0, SL_S+0, SL_X+2);
         7'd30:  u = mk(OP_MADD, 0, 0, SL_S+1, SL_Y+2);
         7'd31:  u = mk(OP_MADD, 0, 0, SL_S+2, SL_Z+2);
         7'd32:  u = mk(OP_STORE, 0, SL_W+2, 0, 0);
         7'd33:  u = mk(OP_FETCH, 3, 0, 0, 0);
         7'd34:  u = mk(OP_DIFF, 0, SL_X+3, 0, 0);
         7'd35:  u = mk(OP_DIFF, 1, SL_Y+3, 0, 0);
         7'd36:  u = mk(OP_DIFF, 2, SL_Z+3, 0, 0);
         7'd37:  u = mk(OP_SUM, 0, SL_S+0, 0, 0);
         7'd38:  u = mk(OP_SUM, 1, SL_S+1, 0, 0);
         7'd39:  u = mk(OP_SUM, 2, SL_S+2, 0, 0);
         7'd40:  u = mk(OP_MSET, 0, 0, SL_S+0, SL_X+3);
         7'd41:  u = mk(OP_MADD, 0, 0, SL_S+1, SL_Y+3);
         7'd42:  u = mk(OP_MADD, 0, 0, SL_S+2, SL_Z+3);
         7'd43:  u = mk(OP_STORE, 0, SL_W+3, 0, 0);
         // sphere: a_k = x_i*y_j - x_j*y_i
         7'd44:  u = mk(OP_MSET, 0, 0, SL_X+0, SL_Y+1);
         7'd45:  u = mk(OP_MSUB, 0, 0, SL_X+1, SL_Y+0);
         7'd46:  u = mk(OP_STORE, 0, SL_A+0, 0, 0);
         7'd47:  u = mk(OP_MSET, 0, 0, SL_X+0, SL_Y+2);
         7'd48:  u = mk(OP_MSUB, 0, 0, SL_X+2, SL_Y+0);
         7'd49:  u = mk(OP_STORE, 0, SL_A+1, 0, 0);
         7'd50:  u = mk(OP_MSET, 0, 0, SL_X+0, SL_Y+3);
         7'd51:  u = mk(OP_MSUB, 0, 0, SL_X+3, SL_Y+0);
         7'd52:  u = mk(OP_STORE, 0, SL_A+2, 0, 0);
         7'd53:  u = mk(OP_MSET, 0, 0, SL_X+1, SL_Y+2);
         7'd54:  u = mk(OP_MSUB, 0, 0, SL_X+2, SL_Y+1);
         7'd55:  u = mk(OP_STORE, 0, SL_A+3, 0, 0);
         7'd56:  u = mk(OP_MSET, 0, 0, SL_X+1, SL_Y+3);
         7'd57:  u = mk(OP_MSUB, 0, 0, SL_X+3, SL_Y+1);
         7'd58:  u = mk(OP_STORE, 0, SL_A+4, 0, 0);
         7'd59:  u = mk(OP_MSET, 0, 0, SL_X+2, SL_Y+3);
         7'd60:  u = mk(OP_MSUB, 0, 0, SL_X+3, SL_Y+2);
         7'd61:  u = mk(OP_STORE, 0, SL_A+5, 0, 0);
         // sphere: b_k = z_i*w_j - z_j*w_i, wide operand first
         7'd62:  u = mk(OP_MSET, 0, 0, SL_W+1, SL_Z+0);
         7'd63:  u = mk(OP_MSUB, 0, 0, SL_W+0, SL_Z+1);
         7'd64:  u = mk(OP_STORE, 0, SL_B+0, 0, 0);
         7'd65:  u = mk(OP_MSET, 0, 0, SL_W+2, SL_Z+0);
         7'd66:  u = mk(OP_MSUB, 0, 0, SL_W+0, SL_Z+2);
         7'd67:  u = mk(OP_STORE, 0, SL_B+1, 0, 0);
         7'd68:  u = mk(OP_MSET, 0, 0, SL_W+3, SL_Z+0);
         7'd69:  u = mk(OP_MSUB, 0, 0, SL_W+0, SL_Z+3);
         7'd70:  u = mk(OP_STORE, 0, SL_B+2, 0, 0);
         7'd71:  u = mk(OP_MSET, 0, 0, SL_W+2, SL_Z+1);
         7'd72:  u = mk(OP_MSUB, 0, 0, SL_W+1, SL_Z+2);
         7'd73:  u = mk(OP_STORE, 0, SL_B+3, 0, 0);
         7'd74:  u = mk(OP_MSET, 0, 0, SL_W+3, SL_Z+1);
         7'd75:  u = mk(OP_MSUB, 0, 0, SL_W+1, SL_Z+3);
         7'd76:  u = mk(OP_STORE, 0, SL_B+4, 0, 0);
         7'd77:  u = mk(OP_MSET, 0, 0, SL_W+3, SL_Z+2);
         7'd78:  u = mk(OP_MSUB, 0, 0, SL_W+2, SL_Z+3);
         7'd79:  u = mk(OP_STORE, 0, SL_B+5, 0, 0);
         // sphere: determinant
         7'd80:  u = mk(OP_MSET, 0, 0, SL_B+5, SL_A+0);
         7'd81:  u = mk(OP_MSUB, 0, 0, SL_B+4, SL_A+1);
         7'd82:  u = mk(OP_MADD, 0, 0, SL_B+3, SL_A+2);
         7'd83:  u = mk(OP_MADD, 0, 0, SL_B+2, SL_A+3);
         7'd84:  u = mk(OP_MSUB, 0, 0, SL_B+1, SL_A+4);
         7'd85:  u = mk(OP_MADD, 0, 0, SL_B+0, SL_A+5);
         7'd86:  u = mk(OP_DONE, 0, 0, 0, 0);
         // plane: d_i = v_i - p
         7'd87:  u = mk(OP_FETCH, 0, 0, 0, 0);
         7'd88:  u = mk(OP_DIFF, 0, SL_X+0, 0, 0);
         7'd89:  u = mk(OP_DIFF, 1, SL_Y+0, 0, 0);
         7'd90:  u = mk(OP_DIFF, 2, SL_Z+0, 0, 0);
         7'd91:  u = mk(OP_FETCH, 1, 0, 0, 0);
         7'd92:  u = mk(OP_DIFF, 0, SL_X+1, 0, 0);
         7'd93:  u = mk(OP_DIFF, 1, SL_Y+1, 0, 0);
         7'd94:  u = mk(OP_DIFF, 2, SL_Z+1, 0, 0);
         7'd95:  u = mk(OP_FETCH, 2, 0, 0, 0);
         7'd96:  u = mk(OP_DIFF, 0, SL_X+2, 0, 0);
         7'd97:  u = mk(OP_DIFF, 1, SL_Y+2, 0, 0);
         7'd98:  u = mk(OP_DIFF, 2, SL_Z+2, 0, 0);
         // plane: rows r1 = d1 - d0, r2 = d2 - d0, r0 taken as d0
         7'd99:  u = mk(OP_SUB, 0, SL_R1+0, SL_X+1, SL_X+0);
         7'd100: u = mk(OP_SUB, 0, SL_R1+1, SL_Y+1, SL_Y+0);
         7'd101: u = mk(OP_SUB, 0, SL_R1+2, SL_Z+1, SL_Z+0);
         7'd102: u = mk(OP_SUB, 0, SL_R2+0, SL_X+2, SL_X+0);
         7'd103: u = mk(OP_SUB, 0, SL_R2+1, SL_Y+2, SL_Y+0);
         7'd104: u = mk(OP_SUB, 0, SL_R2+2, SL_Z+2, SL_Z+0);
         // plane: cofactors
         7'd105: u = mk(OP_MSET, 0, 0, SL_R1+1, SL_R2+2);
         7'd106: u = mk(OP_MSUB, 0, 0, SL_R2+1, SL_R1+2);
         7'd107: u = mk(OP_STORE, 0, SL_C+0, 0, 0);
         7'd108: u = mk(OP_MSET, 0, 0, SL_R2+1, SL_Z+0);
         7'd109: u = mk(OP_MSUB, 0, 0, SL_Y+0, SL_R2+2);
         7'd110: u = mk(OP_STORE, 0, SL_C+1, 0, 0);
         7'd111: u = mk(OP_MSET, 0, 0, SL_Y+0, SL_R1+2);
         7'd112: u = mk(OP_MSUB, 0, 0, SL_R1+1, SL_Z+0);
         7'd113: u = mk(OP_STORE, 0, SL_C+2, 0, 0);
         // plane: determinant, sign flipped since r0 = -d0
         7'd114: u = mk(OP_MSET, 0, 0, SL_C+0, SL_X+0);
         7'd115: u = mk(OP_MADD, 0, 0, SL_C+1, SL_R1+0);
         7'd116: u = mk(OP_MADD, 0, 0, SL_C+2, SL_R2+0);
         7'd117: u = mk(OP_DONE, 1, 0, 0, 0);
         // vertex load
         7'd118: u = mk(OP_WRV, 0, 0, 0, 0);
         default: u = mk(OP_END, 0, 0, 0, 0);
      endcase
      return u;
   endfunction

endpackage

// ===== hdl/eois_dpath.sv =====
module eois_dpath #(
   parameter int VERTEX_COUNT = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                                             clock,
   input  eois_pkg::cmd_type                                cmd,
   input  logic [3:0][eois_pkg::INDEX_BITS-1:0]             req_index,
   input  logic [2:0][eois_pkg::FIELD_BITS-1:0]             req_point,
   output eois_pkg::stat_type                               stat
);
   import eois_pkg::*;

   localparam int CW       = COORD_BITS;
   localparam int RW       = 5 * CW + 12;
   localparam int XW       = 3 * CW + 6;
   localparam int ND       = (2 * CW + 3 + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int YW       = ND * DIGIT_BITS;
   localparam int AW       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int RSH      = 28;
   localparam int RECIP_W  = 27;
   localparam int VC_W     = 17;
   localparam longint RECIP = ((64'd1 << RSH) + VERTEX_COUNT - 1) / VERTEX_COUNT;
   localparam int SCR_DEPTH = 1 << SLOT_BITS;

   // stores
   logic        [3*CW-1:0] vtx_mem [VERTEX_COUNT];
   logic signed [RW-1:0]   sr_mem  [SCR_DEPTH];

   logic [2:0][CW-1:0]            p_ff;
   logic [3:0][INDEX_BITS-1:0]    idx_ff;
   logic [INDEX_BITS-1:0]         nidx_ff;
   logic [INDEX_BITS-1:0]         q_ff;
   logic [3*CW-1:0]               vtx_ff;
   logic signed [RW-1:0]          rd_a_ff;
   logic signed [RW-1:0]          rd_b_ff;
   logic signed [RW-1:0]          acc_ff;
   logic signed [RW-1:0]          acc_in;

   logic [INDEX_BITS-1:0]         idx_sel;
   logic [INDEX_BITS+RECIP_W-1:0] qprod;
   logic [INDEX_BITS+VC_W-1:0]    qv;
   logic [INDEX_BITS+VC_W-1:0]    rem;
   logic [AW-1:0]                 vaddr;

   logic signed [CW-1:0]          vk;
   logic signed [CW-1:0]          pk;
   logic signed [RW-1:0]          wr_data;
   logic                          wr_en;

   logic signed [XW-1:0]          xop;
   logic [YW-1:0]                 ysh;
   logic [DIGIT_BITS-1:0]         dig;
   logic signed [DIGIT_BITS:0]    dig_s;
   logic signed [XW+DIGIT_BITS:0] prod;
   logic signed [RW-1:0]          term;
   logic signed [RW-1:0]          base;
   logic                          is_mul;

   // field to coordinate: low COORD_BITS bits, zero above the field
   function automatic logic [CW-1:0] coord_of(input logic [FIELD_BITS-1:0] f);
      logic [CW+FIELD_BITS-1:0] fz;
      fz = {{CW{1'b0}}, f};
      return fz[CW-1:0];
   endfunction

   // latch query point and indices on transfer
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         p_ff[0] <= coord_of(req_point[0]);
         p_ff[1] <= coord_of(req_point[1]);
         p_ff[2] <= coord_of(req_point[2]);
         idx_ff  <= req_index;
      end
   end

   // index reduction: quotient by reciprocal, then remainder
   assign idx_sel = idx_ff[cmd.uop.sel];
   assign qprod   = idx_sel * RECIP_W'(RECIP);
   assign qv      = q_ff * VC_W'(VERTEX_COUNT);
   assign rem     = (INDEX_BITS+VC_W)'(nidx_ff) - qv;
   assign vaddr   = rem[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.issue && (cmd.uop.op == OP_FETCH || cmd.uop.op == OP_WRV)) begin
         nidx_ff <= idx_sel;
         q_ff    <= qprod[RSH+INDEX_BITS-1:RSH];
      end
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (cmd.exec && cmd.uop.op == OP_WRV) begin
         vtx_mem[vaddr] <= {p_ff[2], p_ff[1], p_ff[0]};
      end
      if (cmd.exec && cmd.uop.op == OP_FETCH) begin
         vtx_ff <= vtx_mem[vaddr];
      end
   end

   // scratch reads
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_a_ff <= sr_mem[cmd.uop.src_a];
         rd_b_ff <= sr_mem[cmd.uop.src_b];
      end
   end

   // coordinate select and adder
   always_comb begin
      case (cmd.uop.sel)
         2'd1: begin
            vk = vtx_ff[CW +: CW];
            pk = p_ff[1];
         end
         2'd2: begin
            vk = vtx_ff[2*CW +: CW];
            pk = p_ff[2];
         end
         default: begin
            vk = vtx_ff[CW-1:0];
            pk = p_ff[0];
         end
      endcase
      case (cmd.uop.op)
         OP_DIFF: wr_data = RW'(vk) - RW'(pk);
         OP_SUM:  wr_data = RW'(vk) + RW'(pk);
         OP_SUB:  wr_data = rd_a_ff - rd_b_ff;
         default: wr_data = acc_ff;
      endcase
      wr_en = cmd.exec && (cmd.uop.op == OP_DIFF || cmd.uop.op == OP_SUM ||
                           cmd.uop.op == OP_SUB  || cmd.uop.op == OP_STORE);
   end

   // scratch write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sr_mem[cmd.uop.dst] <= wr_data;
      end
   end

   // digit-serial multiply-accumulate, top digit signed
   always_comb begin
      is_mul = (cmd.uop.op == OP_MSET || cmd.uop.op == OP_MADD || cmd.uop.op == OP_MSUB);
      xop    = rd_a_ff[XW-1:0];
      ysh    = rd_b_ff[YW-1:0] >> (DIGIT_BITS * cmd.digit);
      dig    = ysh[DIGIT_BITS-1:0];
      if (cmd.digit == DIGIT_CNT_BITS'(ND - 1)) begin
         dig_s = {dig[DIGIT_BITS-1], dig};
      end else begin
         dig_s = {1'b0, dig};
      end
      prod = xop * dig_s;
      term = RW'(prod) <<< (DIGIT_BITS * cmd.digit);
      if (cmd.uop.op == OP_MSET && cmd.digit == '0) begin
         base = '0;
      end else begin
         base = acc_ff;
      end
      if (cmd.uop.op == OP_MSUB) begin
         acc_in = base - term;
      end else begin
         acc_in = base + term;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && is_mul) begin
         acc_ff <= acc_in;
      end
   end

   // sign status
   assign stat.neg  = acc_ff[RW-1];
   assign stat.zero = (acc_ff == '0);

endmodule

// ===== hdl/eois_ctrl.sv =====
module eois_ctrl #(
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_kind,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_side,
   output logic               rsp_was_sphere,
   output eois_pkg::cmd_type  cmd,
   input  eois_pkg::stat_type stat
);
   import eois_pkg::*;

   localparam int ND = (2 * COORD_BITS + 3 + DIGIT_BITS - 1) / DIGIT_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [1:0] SIDE_ZERO = 2'b00;
   localparam logic [1:0] SIDE_POS  = 2'b01;
   localparam logic [1:0] SIDE_NEG  = 2'b11;

   logic [1:0]                state_ff, state_in;
   logic [PC_BITS-1:0]        pc_ff, pc_in;
   logic [DIGIT_CNT_BITS-1:0] digit_ff, digit_in;
   logic                      sphere_ff, sphere_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                side_ff, side_in;
   logic                      was_sphere_ff, was_sphere_in;

   uop_type                   uop;
   logic                      accept;
   logic                      is_mul;

   assign uop    = ucode(pc_ff);
   assign accept = (state_ff == ST_IDLE) && req_tvalid;
   assign is_mul = (uop.op == OP_MSET || uop.op == OP_MADD || uop.op == OP_MSUB);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      digit_in      = digit_ff;
      sphere_in     = sphere_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      side_in       = side_ff;
      was_sphere_in = was_sphere_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     pc_in    = PC_LOAD;
                     state_in = ST_ISSUE;
                  end
                  KIND_PLANE: begin
                     pc_in     = PC_PLANE;
                     sphere_in = 1'b0;
                     state_in  = ST_ISSUE;
                  end
                  KIND_SPHERE: begin
                     pc_in     = PC_SPHERE;
                     sphere_in = 1'b1;
                     state_in  = ST_ISSUE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            if (uop.op == OP_DONE) begin
               state_in = ST_FINISH;
            end else if (uop.op == OP_END) begin
               state_in = ST_IDLE;
            end else begin
               digit_in = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_mul && digit_ff != DIGIT_CNT_BITS'(ND - 1)) begin
               digit_in = digit_ff + 1'b1;
            end else begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               was_sphere_in = sphere_ff;
               if (stat.zero) begin
                  side_in = SIDE_ZERO;
               end else if (stat.neg ^ uop.sel[0]) begin
                  side_in = SIDE_NEG;
               end else begin
                  side_in = SIDE_POS;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         digit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         digit_ff     <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      sphere_ff     <= sphere_in;
      side_ff       <= side_in;
      was_sphere_ff <= was_sphere_in;
   end

   // datapath commands
   assign cmd.latch = accept;
   assign cmd.issue = (state_ff == ST_ISSUE);
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.uop   = uop;
   assign cmd.digit = digit_ff;

   assign req_tready     = (state_ff == ST_IDLE);
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_side       = side_ff;
   assign rsp_was_sphere = was_sphere_ff;

endmodule

// ===== hdl/exact_orient_insphere_sign_unit.sv =====
// channel  dir  tdata fields (low bit up)                        tuser
// req_     in   vertex_index_0..3 (10 each), point_x/y/z (16 each)  kind (2)
// rsp_     out  side (2), zero fill to 8                         was_sphere (1)
//
// ND = ceil((2*COORD_BITS+3)/16) digits per multiply on one shared multiplier.
// load, plane and sphere items run as micro-programs stepped by the micro-op sequencer.
// one item at a time; the next transfer is taken while a result waits in rsp_.
// reset is synchronous; the vertex table holds no reset value.
module exact_orient_insphere_sign_unit #(
   parameter int VERTEX_COUNT = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // vertex_index_0..3, point_x, point_y, point_z
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // side, zero fill
   output logic [0:0]  rsp_tuser    // was_sphere
);
   import eois_pkg::*;

   cmd_type                    cmd;
   stat_type                   stat;
   logic [3:0][INDEX_BITS-1:0] req_index;
   logic [2:0][FIELD_BITS-1:0] req_point;
   logic [1:0]                 side;
   logic                       was_sphere;

   assign req_index = req_tdata[4*INDEX_BITS-1:0];
   assign req_point = req_tdata[4*INDEX_BITS +: 3*FIELD_BITS];

   // sequencer
   eois_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_kind       (req_tuser),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_side       (side),
      .rsp_was_sphere (was_sphere),
      .cmd            (cmd),
      .stat           (stat)
   );

   // arithmetic and stores
   eois_dpath #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .COORD_BITS   (COORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .req_index (req_index),
      .req_point (req_point),
      .stat      (stat)
   );

   assign rsp_tdata = {6'b0, side};
   assign rsp_tuser = was_sphere;

   // a load transfer never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == KIND_LOAD && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result raised after a vertex load");

   // a valid kind starts work and drops ready
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser == KIND_LOAD || req_tuser == KIND_PLANE || req_tuser == KIND_SPHERE))
      |=> !req_tready)
      else $error("ready stayed high after starting an item");

   // a new result appears only as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while sequencer busy");

endmodule
